[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helper functions shared by the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    // decoder mode
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX_X  = 3'd2,
        MODE_HEX_U1 = 3'd3,
        MODE_SUR_BS = 3'd4,
        MODE_SUR_U  = 3'd5,
        MODE_HEX_U2 = 3'd6
    } mode_t;

    // result kinds
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_CLOSED = 3'd1;
    localparam logic [2:0] KIND_BADSTR = 3'd2;
    localparam logic [2:0] KIND_BADHEX = 3'd3;
    localparam logic [2:0] KIND_BADUNI = 3'd4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [20:0] SUP_BASE   = 21'h10000;

    // up to four results caused by one request
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      kind;
        logic [2:0]      count;
    } group_t;

    // hex digit value, bit 4 set when the byte is a hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h74:   r = 8'h09;
            8'h72:   r = 8'h0D;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic group_t single(input logic [7:0] b, input logic [2:0] k);
        group_t g;
        g.bytes    = '0;
        g.bytes[0] = b;
        g.kind     = k;
        g.count    = 3'd1;
        return g;
    endfunction

    // code point to utf-8 bytes
    function automatic group_t encode_cp(input logic [20:0] cp);
        group_t g;
        g.bytes = '0;
        g.kind  = KIND_DATA;
        if (cp <= 21'h7F) begin
            g.bytes[0] = cp[7:0];
            g.count    = 3'd1;
        end
        else if (cp <= 21'h7FF) begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.count    = 3'd2;
        end
        else if (cp <= 21'hFFFF) begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.count    = 3'd3;
        end
        else begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.count    = 3'd4;
        end
        return g;
    endfunction

endpackage

[hw/rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// jsu_decode
// escape state machine: turns one request byte into a group of results
// ----------------------------------------------------------------------------
module jsu_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [7:0]       in_byte,
    output jsu_pkg::group_t  group
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     digit_count_reg, digit_count_next;
    logic [15:0]    hex_accum_reg, hex_accum_next;
    logic [9:0]     high_half_reg, high_half_next;

    logic [4:0]     dv;
    logic [15:0]    acc_shift;
    logic [20:0]    pair_cp;
    logic           is_hi_sur;

    assign dv        = jsu_pkg::digit_value(in_byte);
    assign acc_shift = {hex_accum_reg[11:0], dv[3:0]};
    assign pair_cp   = jsu_pkg::SUP_BASE + {1'b0, high_half_reg, 10'd0}
                     + {11'd0, acc_shift[9:0]};
    assign is_hi_sur = acc_shift >= jsu_pkg::SUR_HI_MIN && acc_shift <= jsu_pkg::SUR_HI_MAX;

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            jsu_pkg::MODE_PLAIN:
            begin
                if (in_byte == jsu_pkg::CH_BSL)
                    mode_next = jsu_pkg::MODE_ESC;
            end
            jsu_pkg::MODE_ESC:
            begin
                if (in_byte == jsu_pkg::CH_X)
                    mode_next = jsu_pkg::MODE_HEX_X;
                else if (in_byte == jsu_pkg::CH_U)
                    mode_next = jsu_pkg::MODE_HEX_U1;
                else
                    mode_next = jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_HEX_X:
            begin
                if (!dv[4] || digit_count_reg == 2'd1)
                    mode_next = jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_HEX_U1:
            begin
                if (!dv[4])
                    mode_next = jsu_pkg::MODE_PLAIN;
                else if (digit_count_reg == 2'd3)
                    mode_next = is_hi_sur ? jsu_pkg::MODE_SUR_BS : jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_HEX_U2:
            begin
                if (!dv[4] || digit_count_reg == 2'd3)
                    mode_next = jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_SUR_BS:
            begin
                mode_next = (in_byte == jsu_pkg::CH_BSL) ? jsu_pkg::MODE_SUR_U
                                                          : jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_SUR_U:
            begin
                mode_next = (in_byte == jsu_pkg::CH_U) ? jsu_pkg::MODE_HEX_U2
                                                        : jsu_pkg::MODE_PLAIN;
            end
            default:
            begin
                mode_next = jsu_pkg::MODE_PLAIN;
            end
        endcase
    end

    // results and data registers
    always_comb
    begin
        group            = '0;
        digit_count_next = digit_count_reg;
        hex_accum_next   = hex_accum_reg;
        high_half_next   = high_half_reg;
        case (mode_reg)
            jsu_pkg::MODE_PLAIN:
            begin
                if (in_byte == jsu_pkg::CH_NUL || in_byte == jsu_pkg::CH_LF)
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_BADSTR);
                else if (in_byte == jsu_pkg::CH_QUOTE)
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_CLOSED);
                else if (in_byte != jsu_pkg::CH_BSL)
                    group = jsu_pkg::single(in_byte, jsu_pkg::KIND_DATA);
            end
            jsu_pkg::MODE_ESC:
            begin
                digit_count_next = 2'd0;
                hex_accum_next   = 16'd0;
                if (in_byte != jsu_pkg::CH_X && in_byte != jsu_pkg::CH_U)
                    group = jsu_pkg::single(jsu_pkg::escape_map(in_byte),
                                            jsu_pkg::KIND_DATA);
            end
            jsu_pkg::MODE_HEX_X:
            begin
                if (!dv[4])
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_BADHEX);
                else
                begin
                    hex_accum_next   = acc_shift;
                    digit_count_next = digit_count_reg + 2'd1;
                    if (digit_count_reg == 2'd1)
                        group = jsu_pkg::single(acc_shift[7:0], jsu_pkg::KIND_DATA);
                end
            end
            jsu_pkg::MODE_HEX_U1,
            jsu_pkg::MODE_HEX_U2:
            begin
                if (!dv[4])
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_BADUNI);
                else
                begin
                    hex_accum_next   = acc_shift;
                    digit_count_next = digit_count_reg + 2'd1;
                    if (digit_count_reg == 2'd3)
                    begin
                        if (mode_reg == jsu_pkg::MODE_HEX_U2)
                            group = jsu_pkg::encode_cp(pair_cp);
                        else if (is_hi_sur)
                            high_half_next = acc_shift[9:0];
                        else
                            group = jsu_pkg::encode_cp({5'd0, acc_shift});
                    end
                end
            end
            jsu_pkg::MODE_SUR_BS:
            begin
                if (in_byte != jsu_pkg::CH_BSL)
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_BADUNI);
            end
            jsu_pkg::MODE_SUR_U:
            begin
                if (in_byte == jsu_pkg::CH_U)
                begin
                    digit_count_next = 2'd0;
                    hex_accum_next   = 16'd0;
                end
                else
                    group = jsu_pkg::single(8'd0, jsu_pkg::KIND_BADUNI);
            end
            default:
            begin
                group = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= jsu_pkg::MODE_PLAIN;
            digit_count_reg <= 2'd0;
            hex_accum_reg   <= 16'd0;
            high_half_reg   <= 10'd0;
        end
        else if (en)
        begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
            hex_accum_reg   <= hex_accum_next;
            high_half_reg   <= high_half_next;
        end
    end

endmodule

[hw/rtl/jsu_emit.sv]
// ----------------------------------------------------------------------------
// jsu_emit
// result register: holds one group and hands out its results in order
// ----------------------------------------------------------------------------
module jsu_emit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::group_t  group,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [2:0]       kind,
    output logic             last
);

    jsu_pkg::group_t group_reg;
    logic            busy_reg, busy_next;
    logic [1:0]      idx_reg, idx_next;
    logic            take;

    assign out_valid = busy_reg;
    assign out_byte  = group_reg.bytes[idx_reg];
    assign kind      = group_reg.kind;
    assign last      = ({1'b0, idx_reg} + 3'd1) == group_reg.count;
    assign take      = busy_reg && out_ready;
    // group register can take a new group once the final result leaves
    assign free      = !busy_reg || (take && last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
            idx_next = idx_reg + 2'd1;
        if (free)
        begin
            busy_next = load;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            group_reg <= group;
    end

endmodule

[hw/rtl/json_string_unescape_utf8_top.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// json string body decoder: unescapes bytes and writes code points as utf-8
// ----------------------------------------------------------------------------
//
//  channel | signals                         | direction | meaning
//  --------+---------------------------------+-----------+-----------------------------
//  in      | in_valid in_ready in_byte       | in        | one raw string body byte
//  out     | out_valid out_ready out_byte    | out       | one result, kind gives type,
//          | kind last                       |           | last marks end of a request
//
//  each request is decoded in the cycle it is accepted and its results (zero to
//  four) land in the result register; while out_ready is high one result leaves
//  per cycle; a request giving several results holds the result register until
//  they drain; quiet bytes and single results run at one per cycle when not stalled
//  in_ready is high while the result register is empty or its final result is
//  being taken, so output stalls hold the input back
//  rst_n clears the decoder mode, digit state and result register valid
//
module json_string_unescape_utf8_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       last
);

    jsu_pkg::group_t group;
    logic            accept;
    logic            free;

    // a request is taken whenever the result register has room for its group
    assign in_ready = free;
    assign accept   = in_valid && free;

    // escape state machine, advances only on an accepted request
    jsu_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .in_byte (in_byte),
        .group   (group)
    );

    // quiet bytes give an empty group and load nothing
    jsu_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && (group.count != 3'd0)),
        .group     (group),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .last      (last)
    );

endmodule
